// File: rtl/core/serial_flash_page_read_sequencer_assert.svh
// Assertion macros for the page read sequencer.
// SFPRS_ASSERT   : clocked check, quiet while reset is high.
// SFPRS_ASSERT_R : clocked check that also holds during reset.
`ifndef SERIAL_FLASH_PAGE_READ_SEQUENCER_ASSERT_SVH
`define SERIAL_FLASH_PAGE_READ_SEQUENCER_ASSERT_SVH
`ifndef SYNTHESIS
`define SFPRS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sfprs assertion failed");
`define SFPRS_ASSERT_R(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("sfprs assertion failed");
`else
`define SFPRS_ASSERT(lbl, clk, rst, prop)
`define SFPRS_ASSERT_R(lbl, clk, prop)
`endif
`endif

// File: rtl/core/sfprs_pkg.sv
package sfprs_pkg;

   localparam int PAGE_W      = 14;
   localparam int BYTE_W      = 8;
   localparam int CNT_W       = 10;
   localparam int PAGE_BYTES  = 528;
   localparam int DUMMY_COUNT = 4;
   localparam int CMD_BEATS   = 4 + DUMMY_COUNT;
   localparam int BEAT_W      = $clog2(CMD_BEATS);

   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = PAGE_W;

   localparam logic [BYTE_W-1:0] READ_OPCODE = 8'hD2;
   localparam logic [BYTE_W-1:0] ADDR_PAD    = 8'h00;

   localparam logic [CSR_IDX_W-1:0] CSR_LAST_PAGE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DUMMY_FILL = 1'd1;

   localparam logic [1:0] CS_NONE = 2'd0;
   localparam logic [1:0] CS_ONE  = 2'd1;
   localparam logic [1:0] CS_TWO  = 2'd2;

   localparam logic OP_START = 1'b0;
   localparam logic OP_RX    = 1'b1;

   localparam logic KIND_CMD  = 1'b0;
   localparam logic KIND_DATA = 1'b1;

   // command beat positions
   localparam logic [BEAT_W-1:0] BEAT_OPCODE  = BEAT_W'(0);
   localparam logic [BEAT_W-1:0] BEAT_ADDR_HI = BEAT_W'(1);
   localparam logic [BEAT_W-1:0] BEAT_ADDR_LO = BEAT_W'(2);
   localparam logic [BEAT_W-1:0] BEAT_PAD     = BEAT_W'(3);
   localparam logic [BEAT_W-1:0] BEAT_LAST    = BEAT_W'(CMD_BEATS - 1);

   typedef struct packed {
      logic              operation;
      logic [PAGE_W-1:0] page;
      logic [BYTE_W-1:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic              kind;
      logic [1:0]        chip_select;
      logic [BYTE_W-1:0] tx_byte;
      logic [BYTE_W-1:0] data_byte;
      logic [CNT_W-1:0]  byte_index;
      logic              last;
   } rsp_type;

   // hand-off from request decode to the response sequencer
   typedef struct packed {
      logic              load;
      logic              start;
      logic [1:0]        chip;
      logic [BYTE_W-1:0] addr_hi;
      logic [BYTE_W-1:0] addr_lo;
      logic [BYTE_W-1:0] fill;
      rsp_type           data_rsp;
   } burst_type;

   function automatic logic [BYTE_W-1:0] descramble(input logic [BYTE_W-1:0] b);
      return ~{b[3:0], b[7:4]};
   endfunction

   function automatic logic [BYTE_W-1:0] cmd_byte(input logic [BEAT_W-1:0] beat,
                                                  input logic [BYTE_W-1:0] hi,
                                                  input logic [BYTE_W-1:0] lo,
                                                  input logic [BYTE_W-1:0] fill);
      logic [BYTE_W-1:0] b;
      case (beat)
         BEAT_OPCODE:  b = READ_OPCODE;
         BEAT_ADDR_HI: b = hi;
         BEAT_ADDR_LO: b = lo;
         BEAT_PAD:     b = ADDR_PAD;
         default:      b = fill;
      endcase
      return b;
   endfunction

endpackage

// File: rtl/core/sfprs_ctrl.sv
`include "serial_flash_page_read_sequencer_assert.svh"

module sfprs_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  sfprs_pkg::req_type                 req_payload,
   input  logic                               csr_we,
   input  logic [sfprs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sfprs_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output sfprs_pkg::burst_type               burst
);
   import sfprs_pkg::*;

   logic [PAGE_W-1:0] last_page_ff;
   logic [BYTE_W-1:0] fill_ff;
   logic              reading_ff, reading_in;
   logic [1:0]        chip_ff, chip_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic              accept;
   logic              to_one;
   logic [PAGE_W-1:0] local_page;
   logic              last_byte;

   assign accept     = req_valid && req_ready;
   assign to_one     = req_payload.page <= last_page_ff;
   assign local_page = to_one ? req_payload.page : (req_payload.page - last_page_ff);
   assign last_byte  = ({1'b0, count_ff} + (CNT_W+1)'(1)) >= (CNT_W+1)'(PAGE_BYTES);

   always_comb begin
      reading_in = reading_ff;
      chip_in    = chip_ff;
      count_in   = count_ff;

      burst.load    = 1'b0;
      burst.start   = 1'b0;
      burst.chip    = to_one ? CS_ONE : CS_TWO;
      burst.addr_hi = BYTE_W'(local_page >> 6);
      burst.addr_lo = {local_page[5:0], 2'b00};
      burst.fill    = fill_ff;
      burst.data_rsp.kind        = KIND_DATA;
      burst.data_rsp.chip_select = chip_ff;
      burst.data_rsp.tx_byte     = fill_ff;
      burst.data_rsp.data_byte   = descramble(req_payload.rx_byte);
      burst.data_rsp.byte_index  = count_ff;
      burst.data_rsp.last        = last_byte;

      if (accept) begin
         if (req_payload.operation == OP_START) begin
            // a start always wins, any read in flight is dropped
            reading_in  = 1'b1;
            chip_in     = to_one ? CS_ONE : CS_TWO;
            count_in    = '0;
            burst.load  = 1'b1;
            burst.start = 1'b1;
         end else if (reading_ff) begin
            burst.load = 1'b1;
            if (last_byte) begin
               reading_in = 1'b0;
               chip_in    = CS_NONE;
               count_in   = '0;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_page_ff <= PAGE_W'(8191);
         fill_ff      <= '0;
         reading_ff   <= 1'b0;
         chip_ff      <= CS_NONE;
         count_ff     <= '0;
      end else begin
         reading_ff <= reading_in;
         chip_ff    <= chip_in;
         count_ff   <= count_in;
         if (csr_we) begin
            case (csr_index)
               CSR_LAST_PAGE:  last_page_ff <= csr_wdata[PAGE_W-1:0];
               CSR_DUMMY_FILL: fill_ff      <= csr_wdata[BYTE_W-1:0];
               default: ;
            endcase
         end
      end
   end

   `SFPRS_ASSERT(a_idle_clean, clock, reset,
      !reading_ff |-> (chip_ff == CS_NONE && count_ff == '0))
   `SFPRS_ASSERT(a_count_range, clock, reset,
      reading_ff |-> ({1'b0, count_ff} < (CNT_W+1)'(PAGE_BYTES)))
   `SFPRS_ASSERT(a_last_ends_read, clock, reset,
      (accept && req_payload.operation == OP_RX && reading_ff && last_byte)
         |=> !reading_ff)

endmodule

// File: rtl/core/sfprs_emit.sv
`include "serial_flash_page_read_sequencer_assert.svh"

module sfprs_emit (
   input  logic                 clock,
   input  logic                 reset,
   input  sfprs_pkg::burst_type burst,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output sfprs_pkg::rsp_type   rsp_payload
);
   import sfprs_pkg::*;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic              cmd_active_ff, cmd_active_in;
   logic [BEAT_W-1:0] beat_ff, beat_in;
   logic [1:0]        chip_ff, chip_in;
   logic [BYTE_W-1:0] hi_ff, hi_in, lo_ff, lo_in, fill_ff, fill_in;

   logic out_free;
   logic more_beats;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign more_beats = cmd_active_ff && (beat_ff != BEAT_LAST);
   assign req_ready  = out_free && !more_beats;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      cmd_active_in = cmd_active_ff;
      beat_in       = beat_ff;
      chip_in       = chip_ff;
      hi_in         = hi_ff;
      lo_in         = lo_ff;
      fill_in       = fill_ff;

      if (out_free) begin
         if (more_beats) begin
            beat_in                = beat_ff + BEAT_W'(1);
            rsp_valid_in           = 1'b1;
            rsp_in.kind            = KIND_CMD;
            rsp_in.chip_select     = chip_ff;
            rsp_in.tx_byte         = cmd_byte(beat_ff + BEAT_W'(1), hi_ff, lo_ff, fill_ff);
            rsp_in.data_byte       = '0;
            rsp_in.byte_index      = '0;
            rsp_in.last            = 1'b0;
         end else if (burst.load && burst.start) begin
            cmd_active_in          = 1'b1;
            beat_in                = BEAT_OPCODE;
            chip_in                = burst.chip;
            hi_in                  = burst.addr_hi;
            lo_in                  = burst.addr_lo;
            fill_in                = burst.fill;
            rsp_valid_in           = 1'b1;
            rsp_in.kind            = KIND_CMD;
            rsp_in.chip_select     = burst.chip;
            rsp_in.tx_byte         = cmd_byte(BEAT_OPCODE, burst.addr_hi, burst.addr_lo,
                                              burst.fill);
            rsp_in.data_byte       = '0;
            rsp_in.byte_index      = '0;
            rsp_in.last            = 1'b0;
         end else if (burst.load) begin
            cmd_active_in = 1'b0;
            rsp_valid_in  = 1'b1;
            rsp_in        = burst.data_rsp;
         end else begin
            cmd_active_in = 1'b0;
            rsp_valid_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         cmd_active_ff <= 1'b0;
         beat_ff       <= '0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         cmd_active_ff <= cmd_active_in;
         beat_ff       <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      chip_ff <= chip_in;
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
      fill_ff <= fill_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `SFPRS_ASSERT(a_chip_on_rsp, clock, reset,
      rsp_valid_ff |-> (rsp_ff.chip_select == CS_ONE || rsp_ff.chip_select == CS_TWO))
   `SFPRS_ASSERT(a_burst_blocks_req, clock, reset,
      more_beats |-> !req_ready)
   `SFPRS_ASSERT(a_burst_is_cmd, clock, reset,
      (rsp_valid_ff && cmd_active_ff) |-> (rsp_ff.kind == KIND_CMD))
   `SFPRS_ASSERT_R(a_reset_quiet, clock,
      $past(reset) |-> (!rsp_valid_ff && !cmd_active_ff))

endmodule

// File: rtl/core/serial_flash_page_read_sequencer.sv
// Channel   | Ports                               | Carries
// ----------+-------------------------------------+-------------------------------------
// request   | req_valid / req_ready / req_payload | page start or one received flash byte
// response  | rsp_valid / rsp_ready / rsp_payload | command byte or descrambled data byte
// csr       | csr_we / csr_index / csr_wdata      | chip boundary page, dummy fill byte
//
// While rsp_ready is high, received bytes go one request and one response per clock.
// A page start gives CMD_BEATS (8) command responses from the response register,
// one per cycle while rsp_ready is high; req_ready stays low until the last is loaded.
// Bytes that arrive while no page read is open are taken and dropped.
// Reset is synchronous, active high; it restores the csr defaults and idles the block.
// A stalled response register holds its value and holds off the request side.

module serial_flash_page_read_sequencer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  sfprs_pkg::req_type                 req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output sfprs_pkg::rsp_type                 rsp_payload,
   input  logic                               csr_we,
   input  logic [sfprs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sfprs_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import sfprs_pkg::*;

   // decoded request headed for the response sequencer
   burst_type burst;

   // request decode: chip select, local page, read state and byte count
   sfprs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .burst       (burst)
   );

   // response register plus command beat counter
   sfprs_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .burst       (burst),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: verif/tb.sv
module tb;
   import sfprs_pkg::*;

   localparam int LIMIT_CYCLES    = 2_000_000;
   localparam int SETTLE_CYCLES   = 4;     // response register plus a little slack
   localparam int HOLD_CYCLES     = 300;   // long receiver hold-off
   localparam int RANDOM_ITEMS    = 180;
   localparam int PHASES          = 6;
   localparam int RESET_LAST_PAGE = 8191;

   // Expected-response store plus a running model of the page read state.
   class page_read_scoreboard;
      rsp_type           expected_q[$];
      logic [PAGE_W-1:0] last_page_one;
      logic [BYTE_W-1:0] fill_byte;
      bit                page_open;
      logic [1:0]        chip;
      int unsigned       byte_pos;
      int                errors, checked, starts, data_bytes, pages_closed, ignored;

      function new();
         last_page_one = PAGE_W'(RESET_LAST_PAGE);
         fill_byte     = '0;
         page_open     = 1'b0;
         chip          = CS_NONE;
         byte_pos      = 0;
         errors        = 0;
         checked       = 0;
         starts        = 0;
         data_bytes    = 0;
         pages_closed  = 0;
         ignored       = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         if (idx == CSR_LAST_PAGE) begin
            last_page_one = value[PAGE_W-1:0];
         end else if (idx == CSR_DUMMY_FILL) begin
            fill_byte = value[BYTE_W-1:0];
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void queue_response(logic kind, logic [BYTE_W-1:0] tx, logic [BYTE_W-1:0] data,
                                   logic [CNT_W-1:0] idx, logic last);
         rsp_type r;
         r.kind        = kind;
         r.chip_select = chip;
         r.tx_byte     = tx;
         r.data_byte   = data;
         r.byte_index  = idx;
         r.last        = last;
         expected_q.push_back(r);
      endfunction

      // Predict what one accepted request produces.
      function void note_request(req_type r);
         logic [PAGE_W-1:0] chip_page;
         logic              final_byte;
         if (r.operation == OP_START) begin
            // pages past the boundary are rebased onto chip two
            if (r.page <= last_page_one) begin
               chip      = CS_ONE;
               chip_page = r.page;
            end else begin
               chip      = CS_TWO;
               chip_page = r.page - last_page_one;
            end
            page_open = 1'b1;
            byte_pos  = 0;
            starts++;
            queue_response(KIND_CMD, READ_OPCODE, '0, '0, 1'b0);
            queue_response(KIND_CMD, chip_page[13:6], '0, '0, 1'b0);
            queue_response(KIND_CMD, {chip_page[5:0], 2'b00}, '0, '0, 1'b0);
            queue_response(KIND_CMD, ADDR_PAD, '0, '0, 1'b0);
            repeat (DUMMY_COUNT) queue_response(KIND_CMD, fill_byte, '0, '0, 1'b0);
         end else if (!page_open) begin
            ignored++;
         end else begin
            final_byte = (byte_pos + 1 >= PAGE_BYTES);
            // swap nibbles, invert
            queue_response(KIND_DATA, fill_byte, {~r.rx_byte[3:0], ~r.rx_byte[7:4]},
                           CNT_W'(byte_pos), final_byte);
            data_bytes++;
            if (final_byte) begin
               page_open = 1'b0;
               chip      = CS_NONE;
               byte_pos  = 0;
               pages_closed++;
            end else begin
               byte_pos++;
            end
         end
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         $display("MISMATCH %s: got 0x%0h, expected 0x%0h (response %0d)",
                  what, got, want, checked);
         errors++;
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            report("response with nothing pending", got, '0);
         end else begin
            want = expected_q.pop_front();
            if (got.kind != want.kind) report("kind", got.kind, want.kind);
            if (got.chip_select != want.chip_select)
               report("chip_select", got.chip_select, want.chip_select);
            if (got.tx_byte != want.tx_byte) report("tx_byte", got.tx_byte, want.tx_byte);
            if (got.data_byte != want.data_byte)
               report("data_byte", got.data_byte, want.data_byte);
            if (got.byte_index != want.byte_index)
               report("byte_index", got.byte_index, want.byte_index);
            if (got.last != want.last) report("last", got.last, want.last);
            checked++;
         end
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_payload;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_payload;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   page_read_scoreboard sb;
   bit                  steady;        // no random gaps on either side while set; a requested hold-off still applies
   bit                  hold_request;  // asks the receiver for a long hold-off
   int                  holds_done;
   int                  work_items;    // requests that the block acts on
   int                  cycles;

   serial_flash_page_read_sequencer u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: a hang or a lost response ends the run here.
   initial begin
      cycles = 0;
      while (cycles < LIMIT_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("Verification failed");
      $finish;
   end

   // Monitor: both channels sampled at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_response(rsp_payload);
         if (req_valid && req_ready) sb.note_request(req_payload);
      end
   end

   // Mostly no gap, some short ones, an occasional long one.
   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Receiver: random back-pressure, plus the long hold-off on request.
   // The hold-off length is counted here, not by the sender.
   initial begin : response_sink
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (!reset) begin
            if (hold_request) begin
               stall_left   = HOLD_CYCLES;
               hold_request = 1'b0;
               holds_done++;
            end
            if (stall_left > 0) begin
               rsp_ready <= 1'b0;
               stall_left--;
            end else begin
               rsp_ready <= 1'b1;
               if (!steady && $urandom_range(0, 99) < 30) stall_left = pick_gap();
            end
         end
      end
   end

   function req_type start_req(logic [PAGE_W-1:0] page);
      req_type r;
      r.operation = OP_START;
      r.page      = page;
      r.rx_byte   = BYTE_W'($urandom_range(0, 255));  // don't-care, randomized anyway
      return r;
   endfunction

   function req_type byte_req(logic [BYTE_W-1:0] rx);
      req_type r;
      r.operation = OP_RX;
      r.page      = PAGE_W'($urandom_range(0, 16383)); // don't-care
      r.rx_byte   = rx;
      return r;
   endfunction

   // Page picks lean on the chip boundary and the ends of the range.
   function logic [PAGE_W-1:0] pick_page();
      int r;
      r = $urandom_range(0, 19);
      case (r)
         0:       return '0;
         1:       return '1;
         2:       return sb.last_page_one;
         3:       return sb.last_page_one + 1'b1;
         4:       return sb.last_page_one - 1'b1;
         default: return PAGE_W'($urandom_range(0, 16383));
      endcase
   endfunction

   // Called and returns at a falling edge. Valid is left high on return so a
   // back-to-back request does not drop it; idle callers lower it.
   task send_request(req_type item);
      int gap;
      if (!(item.operation == OP_RX && !sb.page_open)) work_items++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Stop offering and wait until every predicted response is in.
   task drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      drain();
      // an ignored byte may still be in flight after the last response
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      sb.set_register(idx, value);
   endtask

   // Mostly well-formed reads with random content; the rest is stray bytes
   // and reads cut short by another start.
   task run_random(int target);
      int r, n;
      while (work_items < target) begin
         r = $urandom_range(0, 99);
         if (r < 75) begin
            send_request(start_req(pick_page()));
            n = $urandom_range(0, 40);
            repeat (n) send_request(byte_req(BYTE_W'($urandom_range(0, 255))));
         end else if (r < 90) begin
            n = $urandom_range(1, 3);
            repeat (n) send_request(byte_req(BYTE_W'($urandom_range(0, 255))));
         end else begin
            send_request(start_req(pick_page()));
            send_request(start_req(pick_page()));
            n = $urandom_range(0, 4);
            repeat (n) send_request(byte_req(BYTE_W'($urandom_range(0, 255))));
         end
      end
   endtask

   initial begin
      int per_phase;
      logic [PAGE_W-1:0] bounds [PHASES];
      logic [BYTE_W-1:0] fills  [PHASES];

      sb           = new();
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_payload  = '0;
      csr_we       = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      steady       = 1'b0;
      hold_request = 1'b0;
      holds_done   = 0;
      work_items   = 0;

      // boundary and fill extremes mixed with random settings
      bounds = '{'0, '1, PAGE_W'($urandom_range(1, 16382)), PAGE_W'(1),
                 PAGE_W'($urandom_range(0, 16383)), PAGE_W'(16382)};
      fills  = '{8'hFF, 8'h00, BYTE_W'($urandom_range(0, 255)), 8'hA5,
                 BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255))};

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset settings, byte while idle, both chips, boundary page,
      // top page, restart in the middle of a read.
      send_request(byte_req(8'hA5));
      send_request(start_req('0));
      send_request(byte_req(8'h00));
      send_request(byte_req(8'hFF));
      send_request(byte_req(8'h5A));
      send_request(start_req(PAGE_W'(RESET_LAST_PAGE)));
      send_request(byte_req(8'h0F));
      send_request(start_req(PAGE_W'(RESET_LAST_PAGE + 1)));
      send_request(byte_req(8'hF0));
      send_request(start_req('1));
      send_request(byte_req(8'hC3));
      send_request(byte_req(8'h81));
      drain();

      per_phase = RANDOM_ITEMS / PHASES;
      for (int phase = 0; phase < PHASES; phase++) begin
         // A read may still be open here; the new fill then applies mid-page.
         write_register(CSR_LAST_PAGE, CSR_DATA_W'(bounds[phase]));
         write_register(CSR_DUMMY_FILL, CSR_DATA_W'(fills[phase]));
         steady = (phase == 3);

         if (phase == 0) begin
            // one whole page through to the last byte, then bytes after close
            send_request(start_req(pick_page()));
            repeat (PAGE_BYTES) send_request(byte_req(BYTE_W'($urandom_range(0, 255))));
            repeat (2) send_request(byte_req(BYTE_W'($urandom_range(0, 255))));
         end

         if (phase == 1) begin
            // receiver stalls long; back-to-back requests must back up
            hold_request = 1'b1;
            steady       = 1'b1;
            send_request(start_req(pick_page()));
            repeat (40) send_request(byte_req(BYTE_W'($urandom_range(0, 255))));
            steady       = 1'b0;
         end

         run_random(work_items + per_phase / 2);
         drain();   // sender pause until the pipe is empty
         run_random(work_items + per_phase / 2);
      end

      drain();
      repeat (SETTLE_CYCLES * 4) @(negedge clock);

      $display("Run: %0d page starts, %0d data bytes, %0d pages read to the last byte,",
               sb.starts, sb.data_bytes, sb.pages_closed);
      $display("     %0d idle bytes dropped, %0d responses checked, %0d long hold-offs, %0d cycles",
               sb.ignored, sb.checked, holds_done, cycles);
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
